// ===== design/mgft_pkg.sv =====
// Shared types and constants for the multicast group filter table.
package mgft_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int KEY_W             = 24;
    localparam int ADDR_W            = 32;
    localparam int SLOT_W            = 4;
    localparam int MAC_W             = 48;
    localparam logic [23:0] MAC_PREFIX = 24'h01005E;

    typedef enum logic
    {
        KIND_JOIN  = 1'b0,
        KIND_LEAVE = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        ST_ADDED   = 2'd0,
        ST_FULL    = 2'd1,
        ST_REMOVED = 2'd2,
        ST_ABSENT  = 2'd3
    } status_t;

    // Request token that walks down the row of table cells.
    typedef struct packed
    {
        logic              active;
        kind_t             kind;
        logic [KEY_W-1:0]  key;
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic              any_valid;
    } tok_t;

    function automatic logic [MAC_W-1:0] map_mac(input logic [ADDR_W-1:0] addr);
        map_mac = {MAC_PREFIX, 1'b0, addr[22:16], addr[15:0]};
    endfunction

endpackage

// ===== design/mgft_cell.sv =====
// One table entry that serves the request token and hands it to the next entry.
module mgft_cell
    import mgft_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  tok_t tok_in,
    output tok_t tok_out
);

    localparam logic [SLOT_W-1:0] SLOT_CODE = SLOT_W'(IDX);

    logic             valid_reg;
    logic             valid_next;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    tok_t             tok_reg;
    tok_t             tok_next;
    logic             claim;
    logic             hit;

    always_comb
    begin
        claim      = tok_in.active && (tok_in.kind == KIND_JOIN) && !tok_in.found && !valid_reg;
        hit        = tok_in.active && (tok_in.kind == KIND_LEAVE) && !tok_in.found &&
                     valid_reg && (key_reg == tok_in.key);
        valid_next = valid_reg;
        key_next   = key_reg;
        tok_next   = tok_in;
        if (claim)
        begin
            valid_next = 1'b1;
            key_next   = tok_in.key;
        end
        else if (hit)
        begin
            valid_next = 1'b0;
            key_next   = '0;
        end
        if (claim || hit)
        begin
            tok_next.found = 1'b1;
            tok_next.slot  = SLOT_CODE;
        end
        // Occupancy seen after this entry has been updated.
        tok_next.any_valid = tok_in.any_valid | valid_next;
        if (!tok_in.active)
        begin
            tok_next.active = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign tok_out = tok_reg;

endmodule

// ===== design/multicast_group_filter_table_core.sv =====
// Top level of the multicast group filter table: request intake, cell row and result output.
//
//  channel  dir  tdata                                       tuser
//  s_axis   in   [31:0] group_addr                           [0] kind
//  m_axis   out  [3:0] slot, [4] filter_enabled, [52:5] mac  [1:0] status
//
// One request is in flight at a time. It walks the row of TABLE_ENTRIES cells,
// one cell per cycle, then goes through the result and output registers.
// Reset clears all valid bits and the filter enable at once.
// A result waiting on m_axis does not hold off the next request; only a second
// finished result behind it waits.
module multicast_group_filter_table_core
    import mgft_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [ADDR_W-1:0] s_axis_tdata,   // [31:0] group_addr
    input  logic              s_axis_tuser,   // [0] kind
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [55:0]       m_axis_tdata,   // [3:0] slot, [4] filter_enabled, [52:5] mac_address
    output logic [1:0]        m_axis_tuser    // [1:0] status
);

    tok_t tok [TABLE_ENTRIES+1];

    logic              busy_reg,   busy_next;
    logic              filter_reg, filter_next;
    logic [ADDR_W-1:0] addr_reg,   addr_next;
    logic              pend_reg,   pend_next;
    status_t           pend_status_reg, pend_status_next;
    logic [SLOT_W-1:0] pend_slot_reg,   pend_slot_next;
    logic              pend_filter_reg, pend_filter_next;
    logic              out_valid_reg,   out_valid_next;
    status_t           out_status_reg,  out_status_next;
    logic [SLOT_W-1:0] out_slot_reg,    out_slot_next;
    logic              out_filter_reg,  out_filter_next;
    logic [MAC_W-1:0]  out_mac_reg,     out_mac_next;
    logic              accept;
    logic              out_load;
    tok_t              ex;

    assign s_axis_tready = !busy_reg;
    assign accept        = s_axis_tvalid && !busy_reg;

    always_comb
    begin
        tok[0].active    = accept;
        tok[0].kind      = kind_t'(s_axis_tuser);
        tok[0].key       = s_axis_tdata[KEY_W-1:0];
        tok[0].found     = 1'b0;
        tok[0].slot      = '0;
        tok[0].any_valid = 1'b0;
    end

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        mgft_cell #(
            .IDX(i)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .tok_in (tok[i]),
            .tok_out(tok[i+1])
        );
    end

    assign ex       = tok[TABLE_ENTRIES];
    assign out_load = pend_reg && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        busy_next        = busy_reg;
        filter_next      = filter_reg;
        addr_next        = addr_reg;
        pend_next        = pend_reg;
        pend_status_next = pend_status_reg;
        pend_slot_next   = pend_slot_reg;
        pend_filter_next = pend_filter_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_slot_next    = out_slot_reg;
        out_filter_next  = out_filter_reg;
        out_mac_next     = out_mac_reg;

        if (accept)
        begin
            busy_next = 1'b1;
            addr_next = s_axis_tdata;
        end

        if (ex.active)
        begin
            pend_next      = 1'b1;
            pend_slot_next = ex.slot;
            unique case (ex.kind)
                KIND_JOIN:
                begin
                    pend_status_next = ex.found ? ST_ADDED : ST_FULL;
                    filter_next      = 1'b1;
                end
                KIND_LEAVE:
                begin
                    pend_status_next = ex.found ? ST_REMOVED : ST_ABSENT;
                    if (ex.found)
                    begin
                        filter_next = ex.any_valid;
                    end
                end
                default:
                begin
                    pend_status_next = ST_ABSENT;
                end
            endcase
            pend_filter_next = filter_next;
        end

        if (out_load)
        begin
            pend_next       = 1'b0;
            busy_next       = 1'b0;
            out_valid_next  = 1'b1;
            out_status_next = pend_status_reg;
            out_slot_next   = pend_slot_reg;
            out_filter_next = pend_filter_reg;
            out_mac_next    = map_mac(addr_reg);
        end
        else if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            filter_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            filter_reg    <= filter_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg        <= addr_next;
        pend_status_reg <= pend_status_next;
        pend_slot_reg   <= pend_slot_next;
        pend_filter_reg <= pend_filter_next;
        out_status_reg  <= out_status_next;
        out_slot_reg    <= out_slot_next;
        out_filter_reg  <= out_filter_next;
        out_mac_reg     <= out_mac_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {3'b000, out_mac_reg, out_filter_reg, out_slot_reg};

`ifndef SYNTH
    // A request leaves the cell row only while one is outstanding and unreported.
    a_exit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ex.active |-> (busy_reg && !pend_reg))
        else $error("token left the cell row with no request outstanding");

    // Intake closes for the cycle after a transfer is taken.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second request taken while one is in flight");

    // A join always leaves the filter enabled.
    a_join_enables: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_ADDED || m_axis_tuser == ST_FULL))
            |-> m_axis_tdata[4])
        else $error("join reported with filter disabled");

    // Full and not-present results carry slot zero.
    a_miss_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_FULL || m_axis_tuser == ST_ABSENT))
            |-> (m_axis_tdata[3:0] == 4'd0))
        else $error("miss result with nonzero slot");
`endif

endmodule

// ===== sim/tb_multicast_group_filter_table_core.sv =====
// Self-checking testbench for the multicast group filter table core.
`timescale 1ns / 1ps

module tb_multicast_group_filter_table_core;
    import mgft_pkg::*;

    localparam int ENTRIES      = 16;
    localparam int RANDOM_ITEMS = 1430;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        kind_t             kind;
        logic [ADDR_W-1:0] group_addr;
        int                gap;
    } request_t;

    typedef struct {
        status_t           status;
        logic [SLOT_W-1:0] slot;
        logic              filter_enabled;
        logic [MAC_W-1:0]  mac_address;
    } response_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [ADDR_W-1:0] s_axis_tdata = '0;
    logic              s_axis_tuser = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [55:0]       m_axis_tdata;
    logic [1:0]        m_axis_tuser;

    // Shadow copy of the group table, updated as each request is accepted.
    logic              group_valid [ENTRIES];
    logic [KEY_W-1:0]  group_key [ENTRIES];
    logic              filter_state;

    request_t          pending_requests[$];
    response_t         expected_responses[$];
    logic [KEY_W-1:0]  joined_keys[$];
    logic [KEY_W-1:0]  key_pool [8];

    int                total_requests = 0;
    int                accepted_requests = 0;
    int                mismatch_count = 0;
    int                cycle_count = 0;
    int                gap_left = 0;
    int                stall_left = 0;
    int                ready_phase_left = 0;
    bit                ready_calm = 1'b0;

    multicast_group_filter_table_core #(
        .TABLE_ENTRIES(ENTRIES)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            group_valid[i] = 1'b0;
            group_key[i]   = '0;
        end
        filter_state = 1'b0;
    end

    // Join takes the lowest free slot; leave clears the lowest matching valid slot.
    function automatic response_t predict_group_request(kind_t kind, logic [ADDR_W-1:0] addr);
        response_t        resp;
        logic [KEY_W-1:0] key;
        int               hit;
        logic             any_left;
        key      = addr[KEY_W-1:0];
        hit      = -1;
        any_left = 1'b0;
        resp.slot = '0;
        if (kind == KIND_JOIN)
        begin
            filter_state = 1'b1;
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (hit < 0 && !group_valid[i])
                    hit = i;
            end
            if (hit >= 0)
            begin
                group_valid[hit] = 1'b1;
                group_key[hit]   = key;
                resp.status      = ST_ADDED;
                resp.slot        = hit[SLOT_W-1:0];
            end
            else
            begin
                resp.status = ST_FULL;
            end
        end
        else
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (hit < 0 && group_valid[i] && group_key[i] == key)
                    hit = i;
            end
            if (hit >= 0)
            begin
                group_valid[hit] = 1'b0;
                group_key[hit]   = '0;
                for (int i = 0; i < ENTRIES; i++)
                    any_left |= group_valid[i];
                if (!any_left)
                    filter_state = 1'b0;
                resp.status = ST_REMOVED;
                resp.slot   = hit[SLOT_W-1:0];
            end
            else
            begin
                resp.status = ST_ABSENT;
            end
        end
        resp.filter_enabled = filter_state;
        resp.mac_address    = {MAC_PREFIX, 1'b0, addr[22:16], addr[15:0]};
        return resp;
    endfunction

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Queues a request and keeps a list of the keys the table should hold,
    // so that leaves can be aimed at keys that are really present.
    task automatic queue_request(kind_t kind, logic [ADDR_W-1:0] addr, int gap);
        request_t req;
        req.kind       = kind;
        req.group_addr = addr;
        req.gap        = gap;
        pending_requests.push_back(req);
        total_requests++;
        if (kind == KIND_JOIN)
        begin
            if (joined_keys.size() < ENTRIES)
                joined_keys.push_back(addr[KEY_W-1:0]);
        end
        else
        begin
            for (int i = 0; i < joined_keys.size(); i++)
            begin
                if (joined_keys[i] == addr[KEY_W-1:0])
                begin
                    joined_keys.delete(i);
                    break;
                end
            end
        end
    endtask

    // Stimulus: a directed opening, then bursts that fill, drain or scramble the table.
    initial
    begin
        int               burst_len;
        int               mode;
        bit               calm;
        bit               do_join;
        int               produced;
        logic [KEY_W-1:0] key;
        logic [7:0]       upper;

        for (int i = 0; i < 8; i++)
            key_pool[i] = KEY_W'($urandom());

        queue_request(KIND_LEAVE, 32'h0000_0000, 0);
        queue_request(KIND_JOIN,  32'h0000_0000, 1);
        queue_request(KIND_LEAVE, 32'h0000_0000, 0);
        queue_request(KIND_JOIN,  32'hFFFF_FFFF, 0);
        queue_request(KIND_JOIN,  32'h5E12_3456, 2);
        queue_request(KIND_JOIN,  32'h0012_3456, 0);
        queue_request(KIND_JOIN,  32'h0080_0000, 0);
        for (int i = 0; i < 12; i++)
            queue_request(KIND_JOIN,
                          {8'($urandom_range(0, 255)), 4'hA, 12'(i * 273), 8'h5A}, 0);
        // The table is full now; this join must be refused but still enable the filter.
        queue_request(KIND_JOIN,  32'h7F7F_7F7F, 3);
        queue_request(KIND_LEAVE, 32'hFF12_3456, 0);
        queue_request(KIND_LEAVE, 32'h01AB_CDEF, 0);
        queue_request(KIND_LEAVE, 32'h00FF_FFFF, 0);

        produced = 0;
        while (produced < RANDOM_ITEMS)
        begin
            burst_len = $urandom_range(8, 40);
            mode      = $urandom_range(0, 3);
            calm      = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < burst_len; n++)
            begin
                case (mode)
                    0: do_join = ($urandom_range(0, 99) < 80);
                    1: do_join = ($urandom_range(0, 99) < 20);
                    default: do_join = ($urandom_range(0, 1) == 1);
                endcase
                upper = 8'($urandom());
                if (mode == 3)
                    key = KEY_W'($urandom());
                else if (!do_join && joined_keys.size() > 0 && $urandom_range(0, 99) < 85)
                    key = joined_keys[$urandom_range(0, joined_keys.size() - 1)];
                else if ($urandom_range(0, 1))
                    key = key_pool[$urandom_range(0, 7)];
                else
                    key = KEY_W'($urandom());
                queue_request(do_join ? KIND_JOIN : KIND_LEAVE, {upper, key}, pick_gap(calm));
                produced++;
            end
        end

        while (accepted_requests != total_requests)
            @(negedge clk);
        while (expected_responses.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        request_t req;
        logic     next_valid;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
            gap_left      = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_responses.push_back(
                    predict_group_request(kind_t'(s_axis_tuser), s_axis_tdata));
                accepted_requests++;
            end
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                next_valid = 1'b0;
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_requests.size() > 0)
                begin
                    req          = pending_requests.pop_front();
                    next_valid   = 1'b1;
                    s_axis_tdata <= req.group_addr;
                    s_axis_tuser <= req.kind;
                    gap_left     = req.gap;
                end
                s_axis_tvalid <= next_valid;
            end
        end
    end

    // Result monitor and back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        response_t exp_resp;
        response_t got;
        logic      next_ready;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status         = status_t'(m_axis_tuser);
                got.slot           = m_axis_tdata[3:0];
                got.filter_enabled = m_axis_tdata[4];
                got.mac_address    = m_axis_tdata[52:5];
                if (expected_responses.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected result transfer: status %0d slot %0d %s",
                                 got.status, got.slot,
                                 $sformatf("filter %0b mac %h",
                                           got.filter_enabled, got.mac_address));
                end
                else
                begin
                    exp_resp = expected_responses.pop_front();
                    if (got.status !== exp_resp.status || got.slot !== exp_resp.slot ||
                        got.filter_enabled !== exp_resp.filter_enabled ||
                        got.mac_address !== exp_resp.mac_address)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("Mismatch: expected status %0d slot %0d filter %0b mac %h",
                                     exp_resp.status, exp_resp.slot,
                                     exp_resp.filter_enabled, exp_resp.mac_address);
                            $display("          got      status %0d slot %0d filter %0b mac %h",
                                     got.status, got.slot,
                                     got.filter_enabled, got.mac_address);
                        end
                    end
                end
            end

            if (ready_phase_left == 0)
            begin
                ready_phase_left = $urandom_range(50, 300);
                ready_calm       = ($urandom_range(0, 2) == 0);
            end
            else
            begin
                ready_phase_left--;
            end

            next_ready = 1'b1;
            if (stall_left > 0)
            begin
                stall_left--;
                next_ready = 1'b0;
            end
            else if (!ready_calm && $urandom_range(0, 99) < 30)
            begin
                stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                           : $urandom_range(10, 40);
                next_ready = 1'b0;
            end
            m_axis_tready <= next_ready;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule

// ===== files.f =====
design/mgft_pkg.sv
design/mgft_cell.sv
design/multicast_group_filter_table_core.sv
sim/tb_multicast_group_filter_table_core.sv
